FILE: rtl/smdc_pkg.sv
// Package for the sliding median deviation cost core.
// Holds sizing constants, controller states and control structs.
package smdc_pkg;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int COST_BITS       = 39;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INSERT,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic evict;
        logic ins_step;
        logic sum_start;
        logic sum_step;
    } cmd_t;

    typedef struct packed {
        logic full_after;
        logic ins_done;
        logic sum_done;
    } stat_t;
endpackage

FILE: rtl/sliding_median_deviation_cost_core.sv
// Stream core for the sliding median deviation cost. Each s_tdata transfer carries one signed
// sample, s_tuser set clears the window before that sample is taken. A cfg transfer sets the
// window size (0 acts as 1, above WINDOW_MAX clamps to WINDOW_MAX) and clears the window; write
// it only while no sample is in flight. Once the window is full every sample gives one cost
// transfer: the sum of absolute deviations from the lower median. Steps, with k the effective
// window size: a sample that leaves the window short of full passes accept, evict and insert;
// once full it passes accept, evict, insert, a serial sum over the k cells and output load,
// and the output load waits while the previous cost still waits on m_tready.
// Depends on smdc_pkg, smdc_ctrl, smdc_datapath.
module sliding_median_deviation_cost_core #(
    parameter int WINDOW_MAX  = smdc_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [smdc_pkg::CFG_BITS-1:0] cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample
    input  logic s_tuser,                            // restart
    output logic m_tvalid,
    input  logic m_tready,
    output logic [39:0] m_tdata                      // cost
);
    import smdc_pkg::*;
    cmd_t cmd;
    stat_t stat;
    logic out_load;
    logic [COST_BITS-1:0] cost;
    assign cfg_ready = 1'b1;
    smdc_ctrl u_ctrl (.clk, .rst_n, .in_go(s_tvalid), .out_free(!m_tvalid || m_tready),
        .stat, .cmd, .in_ready(s_tready), .out_load);
    smdc_datapath #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (.clk, .rst_n,
        .cfg_we(cfg_valid), .cfg_data, .sample(s_tdata[SAMPLE_BITS-1:0]), .restart(s_tuser),
        .cmd, .stat, .cost);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (out_load)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata <= {1'b0, cost};
    end
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !cmd.sum_step)
        else $error("busy accept");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
endmodule

FILE: rtl/smdc_ctrl.sv
// Controller state machine of the sliding median deviation cost core.
// Depends on smdc_pkg.
module smdc_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_go,
    input  logic out_free,
    input  smdc_pkg::stat_t stat,
    output smdc_pkg::cmd_t cmd,
    output logic in_ready,
    output logic out_load
);
    import smdc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_go) state_next = ST_READ;
            ST_READ:   state_next = ST_INSERT;
            ST_INSERT: if (stat.ins_done) state_next = stat.full_after ? ST_SUM : ST_IDLE;
            ST_SUM:    if (stat.sum_done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_go;
            end
            ST_READ:   cmd.evict = 1'b1;
            ST_INSERT:
            begin
                cmd.ins_step = 1'b1;
                cmd.sum_start = stat.ins_done;
            end
            ST_SUM:    cmd.sum_step = 1'b1;
            ST_OUT:    out_load = out_free;
            default:   cmd = '0;
        endcase
    end
endmodule

FILE: rtl/smdc_datapath.sv
// Datapath: arrival ring memory, sorted cell row, cost accumulator.
// Depends on smdc_pkg.
module smdc_datapath #(
    parameter int WINDOW_MAX  = smdc_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [smdc_pkg::CFG_BITS-1:0] cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic restart,
    input  smdc_pkg::cmd_t cmd,
    output smdc_pkg::stat_t stat,
    output logic [smdc_pkg::COST_BITS-1:0] cost
);
    import smdc_pkg::*;

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [CFG_BITS-1:0] wsize_reg;
    logic [CW-1:0] k;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] oldest_reg;
    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cells_reg [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] samp_reg, old_reg;
    logic signed [SAMPLE_BITS-1:0] med_val;
    logic [IW-1:0] med_idx;
    logic evict_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] slot;
    logic [IW-1:0] sidx_reg;
    logic [COST_BITS-1:0] acc_reg;
    logic [WINDOW_MAX-1:0] ge_old, gt_new, eq_old;
    logic [IW:0] rm_pos;
    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0] adiff;

    always_comb
    begin
        if (wsize_reg == '0)
            k = CW'(1);
        else if ({{32-CFG_BITS{1'b0}}, wsize_reg} > 32'(WINDOW_MAX))
            k = CW'(WINDOW_MAX);
        else
            k = CW'(wsize_reg);
    end

    assign fill_next = restart ? '0 : fill_reg;
    assign slot = ({{32-IW{1'b0}}, oldest_reg} < 32'(k)) ? oldest_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= WINDOW_RESET;
            fill_reg <= '0;
            oldest_reg <= '0;
            evict_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            wsize_reg <= cfg_data;
            fill_reg <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (restart)
                oldest_reg <= '0;
            if (fill_next < k)
            begin
                fill_reg <= fill_next + CW'(1);
                evict_reg <= 1'b0;
            end
            else
            begin
                fill_reg <= fill_next;
                evict_reg <= 1'b1;
                oldest_reg <= ({1'b0, slot} + CW'(1) >= k) ? '0 : IW'(slot + IW'(1));
            end
        end
    end

    // ring write/read, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            samp_reg <= sample;
            if (fill_next < k)
                ring[fill_next[IW-1:0]] <= sample;
            else
            begin
                old_reg <= ring[slot];
                ring[slot] <= sample;
            end
        end
    end

    // remove position: first equal cell, else last
    always_comb
    begin
        rm_pos = (IW+1)'(k) - (IW+1)'(1);
        for (int i = WINDOW_MAX - 1; i >= 0; i--)
            if (eq_old[i] && (IW+1)'(i) < (IW+1)'(k))
                rm_pos = (IW+1)'(i);
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            eq_old[i] = cells_reg[i] == old_reg;
            ge_old[i] = (IW+1)'(i) >= rm_pos;
            gt_new[i] = cells_reg[i] > samp_reg;
        end
    end

    // ST_READ does removal (evict) when an old sample leaves; ST_INSERT one pass of insertion
    always_ff @(posedge clk)
    begin
        if (cmd.evict && evict_reg)
        begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
                if (ge_old[i])
                    cells_reg[i] <= cells_reg[i+1];
        end
        else if (cmd.ins_step)
        begin
            for (int i = WINDOW_MAX - 1; i >= 0; i--)
            begin
                if ((IW+1)'(i) < (IW+1)'(cnt_reg) + (IW+1)'(1))
                begin
                    if (i == 0)
                        cells_reg[i] <= (gt_new[0] || cnt_reg == '0) ? samp_reg : cells_reg[0];
                    else if (gt_new[i-1])
                        cells_reg[i] <= cells_reg[i-1];
                    else if (gt_new[i] || (IW+1)'(i) == (IW+1)'(cnt_reg))
                        cells_reg[i] <= samp_reg;
                end
            end
        end
    end

    // cnt = number of cells already present before insertion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= (fill_next < k) ? fill_next : k - CW'(1);
    end

    assign stat.ins_done = 1'b1;
    assign stat.full_after = fill_reg == k;

    // lower median; cells are final throughout ST_SUM
    assign med_idx = IW'((k + CW'(1)) >> 1) - IW'(1);
    assign med_val = cells_reg[med_idx];

    assign diff = $signed({cells_reg[sidx_reg][SAMPLE_BITS-1], cells_reg[sidx_reg]})
                - $signed({med_val[SAMPLE_BITS-1], med_val});
    assign adiff = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - diff : diff;
    assign stat.sum_done = ({1'b0, sidx_reg} == (IW+1)'(k) - (IW+1)'(1)) && cmd.sum_step;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_start)
        begin
            sidx_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            acc_reg <= acc_reg + COST_BITS'(adiff);
            sidx_reg <= sidx_reg + IW'(1);
        end
    end

    assign cost = acc_reg;
endmodule
